// ----- hw/rtl/tmcw_pkg.sv -----
// Shared types and constants of the text mode console writer.
`default_nettype none

package tmcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    localparam logic CFG_DEFAULT_FG = 1'b0;
    localparam logic CFG_DEFAULT_BG = 1'b1;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        FILL_ZERO  = 2'd0,
        FILL_SPACE = 2'd1,
        FILL_BLANK = 2'd2
    } fill_t;

    typedef enum logic [1:0] {
        CNT_ZERO     = 2'd0,
        CNT_ROW_ONE  = 2'd1,
        CNT_LAST_ROW = 2'd2
    } cnt_sel_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_EXEC,
        ST_RDATA,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     calc_addr;
        logic     put_exec;
        logic     rd_capture;
        logic     copy_step;
        logic     fill_step;
        logic     cnt_load;
        cnt_sel_t cnt_sel;
        fill_t    fill_sel;
        logic     cursor_home;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic wrap;
        logic cnt_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/text_mode_console_writer.sv -----
// Top level of the text mode console writer.
`default_nettype none

// A request is taken when start is high while busy is low, and its single result appears
// with done high for exactly one cycle; the receiver cannot stall it. A put that does not
// scroll passes through the states ADDR, EXEC and DONE, a read through ADDR, EXEC, RDATA
// and DONE, and the unused type through ADDR and DONE. The controller then returns to
// idle, where the next request is taken. A clear, in state FILL, writes one cell per cycle
// through the single write port of the cell memory. A put that runs past the last cell
// scrolls: every cell below the top row is copied up one row, then the last row is blanked,
// one cell per cycle. After reset the cell memory is cleared to zero by a pass over every
// cell during which busy stays high; configuration writes are taken at any time, as
// cfg_ready is always high.
module text_mode_console_writer
    import tmcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        char_code,
    input  wire logic [3:0]        fg_color,
    input  wire logic [3:0]        back_color,
    input  wire logic              use_position,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [COL_W-1:0]  col,
    output logic [ROW_W-1:0]       cursor_row,
    output logic [COL_W-1:0]       cursor_col,
    output logic [7:0]             read_char,
    output logic [7:0]             read_attr,
    output logic                   scrolled,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [3:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tmcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tmcw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .char_code    (char_code),
        .fg_color     (fg_color),
        .back_color   (back_color),
        .use_position (use_position),
        .row          (row),
        .col          (col),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .read_char    (read_char),
        .read_attr    (read_attr),
        .scrolled     (scrolled)
    );

    // A transaction on the request side always ends in exactly one done strobe.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done was high for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted request");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while idle");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && scrolled) |-> (cursor_row == ROW_W'(ROWS - 1)) && (cursor_col == '0))
        else $error("cursor not at start of last row after a scroll");

endmodule

`default_nettype wire

// ----- hw/rtl/tmcw_ctrl.sv -----
// Controller state machine of the text mode console writer.
`default_nettype none

module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  dp_status_t      status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.calc_addr = 1'b1;
                unique case (status.req) inside
                    REQ_PUT, REQ_READ:
                    begin
                        state_next = ST_EXEC;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cnt_load    = 1'b1;
                        cmd.cnt_sel     = CNT_ZERO;
                        cmd.fill_sel    = FILL_SPACE;
                        cmd.cursor_home = 1'b1;
                        state_next      = ST_FILL;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_EXEC:
            begin
                if (status.req == REQ_PUT)
                begin
                    cmd.put_exec = 1'b1;
                    if (status.wrap)
                    begin
                        cmd.cnt_load = 1'b1;
                        cmd.cnt_sel  = CNT_ROW_ONE;
                        state_next   = ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.cnt_load = 1'b1;
                cmd.cnt_sel  = CNT_LAST_ROW;
                cmd.fill_sel = FILL_BLANK;
                state_next   = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tmcw_dp.sv -----
// Datapath of the text mode console writer: cell memory, cursor and result registers.
`default_nettype none

module tmcw_dp
    import tmcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  wire logic [1:0]        req_type,
    input  wire logic [7:0]        char_code,
    input  wire logic [3:0]        fg_color,
    input  wire logic [3:0]        back_color,
    input  wire logic              use_position,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [COL_W-1:0]  col,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_index,
    input  wire logic [3:0]        cfg_data,
    output logic [ROW_W-1:0]       cursor_row,
    output logic [COL_W-1:0]       cursor_col,
    output logic [7:0]             read_char,
    output logic [7:0]             read_attr,
    output logic                   scrolled
);

    localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BEG = ADDR_W'(CELLS - COLUMNS);

    logic [15:0]       mem [CELLS];

    logic [3:0]        dfg_reg;
    logic [3:0]        dbg_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ADDR_W-1:0] cnt_reg;
    fill_t             fill_kind_reg;
    logic              copy_pend_reg;
    logic [ADDR_W-1:0] copy_dst_reg;

    req_t              req_reg;
    logic [7:0]        char_reg;
    logic [7:0]        attr_reg;
    logic [ROW_W-1:0]  trow_reg;
    logic [COL_W-1:0]  tcol_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [15:0]       rd_data_reg;
    logic [7:0]        rd_char_reg;
    logic [7:0]        rd_attr_reg;
    logic              scrolled_reg;

    logic [7:0]        dattr;
    logic [7:0]        in_attr;
    logic [ROW_W-1:0]  sat_row;
    logic [COL_W-1:0]  sat_col;
    logic              newline;
    logic              wrap;
    logic [ADDR_W-1:0] cnt_init;
    logic [15:0]       fill_val;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    assign dattr   = {dbg_reg, dfg_reg};
    assign in_attr = {back_color, fg_color};
    assign sat_row = (row >= ROW_W'(ROWS)) ? LAST_ROW : row;
    assign sat_col = (col >= COL_W'(COLUMNS)) ? LAST_COL : col;
    assign newline = (char_reg == NEWLINE_CODE);
    assign wrap    = (trow_reg == LAST_ROW) && (newline || (tcol_reg == LAST_COL));

    assign status.req      = req_reg;
    assign status.wrap     = wrap;
    assign status.cnt_last = (cnt_reg == LAST_CELL);

    always_comb
    begin
        case (cmd.cnt_sel)
            CNT_ROW_ONE:  cnt_init = ROW_STRIDE;
            CNT_LAST_ROW: cnt_init = LAST_ROW_BEG;
            default:      cnt_init = '0;
        endcase
    end

    always_comb
    begin
        case (fill_kind_reg)
            FILL_SPACE: fill_val = {dattr, SPACE_CODE};
            FILL_BLANK: fill_val = {dattr, 8'h00};
            default:    fill_val = 16'h0000;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = {attr_reg, char_reg};
        if (copy_pend_reg)
        begin
            mem_we = 1'b1;
            mem_wa = copy_dst_reg;
            mem_wd = rd_data_reg;
        end
        else if (cmd.fill_step)
        begin
            mem_we = 1'b1;
            mem_wa = cnt_reg;
            mem_wd = fill_val;
        end
        else if (cmd.put_exec && !newline)
        begin
            mem_we = 1'b1;
        end
        mem_ra = cmd.copy_step ? cnt_reg : addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfg_reg       <= 4'd15;
            dbg_reg       <= 4'd0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cnt_reg       <= '0;
            fill_kind_reg <= FILL_ZERO;
            copy_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_DEFAULT_FG)
                begin
                    dfg_reg <= cfg_data;
                end
                else
                begin
                    dbg_reg <= cfg_data;
                end
            end
            copy_pend_reg <= cmd.copy_step;
            if (cmd.cnt_load)
            begin
                cnt_reg       <= cnt_init;
                fill_kind_reg <= cmd.fill_sel;
            end
            else if (cmd.copy_step || cmd.fill_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.cursor_home)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            else if (cmd.put_exec)
            begin
                if (wrap)
                begin
                    cur_row_reg <= LAST_ROW;
                    cur_col_reg <= '0;
                end
                else if (newline || (tcol_reg == LAST_COL))
                begin
                    cur_row_reg <= trow_reg + 1'b1;
                    cur_col_reg <= '0;
                end
                else
                begin
                    cur_row_reg <= trow_reg;
                    cur_col_reg <= tcol_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= cnt_reg - ROW_STRIDE;
        if (cmd.accept)
        begin
            req_reg      <= req_t'(req_type);
            char_reg     <= char_code;
            attr_reg     <= (in_attr == 8'h00) ? dattr : in_attr;
            trow_reg     <= use_position ? sat_row : cur_row_reg;
            tcol_reg     <= use_position ? sat_col : cur_col_reg;
            rd_char_reg  <= 8'h00;
            rd_attr_reg  <= 8'h00;
            scrolled_reg <= 1'b0;
        end
        if (cmd.calc_addr)
        begin
            addr_reg <= ADDR_W'(trow_reg) * ROW_STRIDE + ADDR_W'(tcol_reg);
        end
        if (cmd.put_exec)
        begin
            scrolled_reg <= wrap;
        end
        if (cmd.rd_capture)
        begin
            rd_char_reg <= rd_data_reg[7:0];
            rd_attr_reg <= rd_data_reg[15:8];
        end
    end

    assign cursor_row = cur_row_reg;
    assign cursor_col = cur_col_reg;
    assign read_char  = rd_char_reg;
    assign read_attr  = rd_attr_reg;
    assign scrolled   = scrolled_reg;

endmodule

`default_nettype wire

// ----- tb/sv/text_mode_console_writer_tb.sv -----
// Self-checking testbench for the text mode console writer: directed table, then shaped random.
`default_nettype none

module text_mode_console_writer_tb;
    import tmcw_pkg::*;

    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int DIRECTED_ROWS  = 24;
    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 67;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        req_t        kind;
        logic [7:0]  char_code;
        logic [3:0]  fg_color;
        logic [3:0]  back_color;
        logic        use_position;
        logic [4:0]  row;
        logic [6:0]  col;
    } console_request_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] read_char;
        logic [7:0] read_attr;
        logic       scrolled;
    } console_result_t;

    typedef struct packed {
        console_request_t rq;
        logic             typed;
        console_result_t  want;
    } directed_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             done;
    logic [1:0]       req_type;
    logic [7:0]       char_code;
    logic [3:0]       fg_color;
    logic [3:0]       back_color;
    logic             use_position;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [7:0]       read_char;
    logic [7:0]       read_attr;
    logic             scrolled;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [3:0]       cfg_data;

    logic [15:0]      shadow_cells [CELLS];
    int unsigned      shadow_cursor;
    logic [3:0]       shadow_fg;
    logic [3:0]       shadow_bg;
    console_result_t  pending_results [$];
    int               mismatch_count;
    int               cycle_count;

    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd0,  7'd0},   1'b1,
          '{5'd0,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd31, 7'd127}, 1'b1,
          '{5'd0,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_PUT,   8'h41, 4'h0, 4'h0, 1'b0, 5'd0,  7'd0},   1'b1,
          '{5'd0,  7'd1, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd0,  7'd0},   1'b1,
          '{5'd0,  7'd1, 8'h41, 8'h0F, 1'b0}},
        '{'{REQ_PUT,   8'hFF, 4'hF, 4'hF, 1'b1, 5'd0,  7'd79},  1'b1,
          '{5'd1,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd0,  7'd79},  1'b1,
          '{5'd1,  7'd0, 8'hFF, 8'hFF, 1'b0}},
        '{'{REQ_PUT,   8'h0A, 4'h3, 4'h2, 1'b0, 5'd0,  7'd0},   1'b1,
          '{5'd2,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd1,  7'd0},   1'b1,
          '{5'd2,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_PUT,   8'h00, 4'h1, 4'h0, 1'b1, 5'd31, 7'd127}, 1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h00, 1'b1}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd23, 7'd79},  1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h01, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd0,  7'd0},   1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd24, 7'd5},   1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h0F, 1'b0}},
        '{'{REQ_PUT,   8'h0A, 4'h0, 4'h0, 1'b1, 5'd24, 7'd10},  1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h00, 1'b1}},
        '{'{REQ_NOP,   8'h55, 4'hA, 4'h5, 1'b1, 5'd7,  7'd9},   1'b1,
          '{5'd24, 7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_PUT,   8'h20, 4'hA, 4'h5, 1'b0, 5'd0,  7'd0},   1'b1,
          '{5'd24, 7'd1, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd24, 7'd0},   1'b1,
          '{5'd24, 7'd1, 8'h20, 8'h5A, 1'b0}},
        '{'{REQ_CLEAR, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0,  7'd0},   1'b1,
          '{5'd0,  7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd12, 7'd40},  1'b1,
          '{5'd0,  7'd0, 8'h20, 8'h0F, 1'b0}},
        '{'{REQ_PUT,   8'h7F, 4'h0, 4'h8, 1'b1, 5'd0,  7'd0},   1'b1,
          '{5'd0,  7'd1, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd24, 7'd127}, 1'b1,
          '{5'd0,  7'd1, 8'h20, 8'h0F, 1'b0}},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd31, 7'd0},   1'b1,
          '{5'd0,  7'd1, 8'h20, 8'h0F, 1'b0}},
        '{'{REQ_PUT,   8'h0A, 4'h0, 4'h0, 1'b1, 5'd10, 7'd127}, 1'b1,
          '{5'd11, 7'd0, 8'h00, 8'h00, 1'b0}},
        '{'{REQ_PUT,   8'hC3, 4'h5, 4'h0, 1'b0, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_READ,  8'h00, 4'h0, 4'h0, 1'b1, 5'd11, 7'd0},   1'b0, '0}
    };

    text_mode_console_writer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .req_type     (req_type),
        .char_code    (char_code),
        .fg_color     (fg_color),
        .back_color   (back_color),
        .use_position (use_position),
        .row          (row),
        .col          (col),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .read_char    (read_char),
        .read_attr    (read_attr),
        .scrolled     (scrolled),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic console_result_t console_apply_request(console_request_t rq);
        console_result_t res;
        int unsigned     pos;
        int unsigned     r;
        int unsigned     c;
        int              i;
        logic [7:0]      attr;
        logic [7:0]      blank_attr;
        blank_attr = {shadow_bg, shadow_fg};
        res = '0;
        r = (rq.row >= ROWS) ? ROWS - 1 : rq.row;
        c = (rq.col >= COLUMNS) ? COLUMNS - 1 : rq.col;
        pos = rq.use_position ? r * COLUMNS + c : shadow_cursor;
        case (rq.kind)
            REQ_PUT:
            begin
                attr = {rq.back_color, rq.fg_color};
                if (attr == 8'h00)
                    attr = blank_attr;
                if (rq.char_code == NEWLINE_CODE)
                    pos = (pos / COLUMNS) * COLUMNS + COLUMNS - 1;
                else
                    shadow_cells[pos] = {attr, rq.char_code};
                pos++;
                if (pos >= CELLS)
                begin
                    for (i = 0; i < CELLS - COLUMNS; i++)
                        shadow_cells[i] = shadow_cells[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        shadow_cells[i] = {blank_attr, 8'h00};
                    pos -= COLUMNS;
                    res.scrolled = 1'b1;
                end
                shadow_cursor = pos;
            end
            REQ_READ:
            begin
                {res.read_attr, res.read_char} = shadow_cells[pos];
            end
            REQ_CLEAR:
            begin
                for (i = 0; i < CELLS; i++)
                    shadow_cells[i] = {blank_attr, SPACE_CODE};
                shadow_cursor = 0;
            end
            default:
            begin
            end
        endcase
        res.cursor_row = ROW_W'(shadow_cursor / COLUMNS);
        res.cursor_col = COL_W'(shadow_cursor % COLUMNS);
        return res;
    endfunction

    function automatic console_request_t random_request();
        console_request_t rq;
        int               sel;
        int               pick;
        sel = $urandom_range(0, 99);
        rq.char_code    = 8'($urandom);
        rq.fg_color     = 4'($urandom);
        rq.back_color   = 4'($urandom);
        rq.use_position = 1'($urandom);
        rq.row          = 5'($urandom);
        rq.col          = 7'($urandom);
        if (sel < 60)
        begin
            rq.kind = REQ_PUT;
            if ($urandom_range(0, 5) == 0)
                rq.char_code = NEWLINE_CODE;
            if ($urandom_range(0, 6) == 0)
                {rq.back_color, rq.fg_color} = 8'h00;
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                rq.use_position = 1'b0;
            end
            else if (pick < 7)
            begin
                rq.use_position = 1'b1;
                rq.row = 5'($urandom_range(22, 31));
                rq.col = 7'($urandom_range(72, 127));
            end
            else
            begin
                rq.use_position = 1'b1;
                rq.row = 5'($urandom_range(0, ROWS - 1));
                rq.col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (sel < 88)
        begin
            rq.kind = REQ_READ;
            rq.use_position = ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 1) == 0)
                rq.row = 5'($urandom_range(20, 31));
        end
        else if (sel < 93)
        begin
            rq.kind = REQ_CLEAR;
        end
        else
        begin
            rq.kind = REQ_NOP;
        end
        return rq;
    endfunction

    task automatic issue_request(input console_request_t rq, input int max_gap,
                                 input logic use_typed, input console_result_t typed_want);
        int              gap;
        console_result_t predicted;
        gap = $urandom_range(0, max_gap);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= rq.kind;
        char_code    <= rq.char_code;
        fg_color     <= rq.fg_color;
        back_color   <= rq.back_color;
        use_position <= rq.use_position;
        row          <= rq.row;
        col          <= rq.col;
        do
            @(posedge clk);
        while (busy);
        predicted = console_apply_request(rq);
        pending_results.push_back(use_typed ? typed_want : predicted);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_defaults(input logic [3:0] fg_value, input logic [3:0] bg_value);
        logic fg_first;
        int   k;
        logic idx;
        fg_first = 1'($urandom);
        for (k = 0; k < 2; k++)
        begin
            idx = ((k == 0) == fg_first) ? CFG_DEFAULT_FG : CFG_DEFAULT_BG;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= (idx == CFG_DEFAULT_FG) ? fg_value : bg_value;
            do
                @(posedge clk);
            while (!cfg_ready);
            if (idx == CFG_DEFAULT_FG)
                shadow_fg = fg_value;
            else
                shadow_bg = bg_value;
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        console_result_t got;
        console_result_t want;
        if (rst_n && done)
        begin
            got = {cursor_row, cursor_col, read_char, read_attr, scrolled};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: row %0d col %0d char %h attr %h scrolled %b",
                             got.cursor_row, got.cursor_col, got.read_char, got.read_attr,
                             got.scrolled);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.cursor_row !== want.cursor_row || got.cursor_col !== want.cursor_col ||
                    got.read_char !== want.read_char || got.read_attr !== want.read_attr ||
                    got.scrolled !== want.scrolled)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: expected row %0d col %0d char %h attr %h scr %b, %s",
                                 want.cursor_row, want.cursor_col, want.read_char,
                                 want.read_attr, want.scrolled,
                                 $sformatf("got row %0d col %0d char %h attr %h scr %b",
                                           got.cursor_row, got.cursor_col, got.read_char,
                                           got.read_attr, got.scrolled));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        console_request_t rq;
        int               phase;
        int               n;
        int               quiet_left;
        logic [3:0]       fg_value;
        logic [3:0]       bg_value;
        start          = 1'b0;
        req_type       = REQ_NOP;
        char_code      = 8'h00;
        fg_color       = 4'h0;
        back_color     = 4'h0;
        use_position   = 1'b0;
        row            = '0;
        col            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_DEFAULT_FG;
        cfg_data       = 4'h0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_left     = 0;
        shadow_cursor  = 0;
        shadow_fg      = 4'hF;
        shadow_bg      = 4'h0;
        foreach (shadow_cells[i])
            shadow_cells[i] = 16'h0000;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_table[k])
            issue_request(directed_table[k].rq, 6, directed_table[k].typed,
                          directed_table[k].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: begin fg_value = 4'h0; bg_value = 4'h0; end
                1: begin fg_value = 4'hF; bg_value = 4'hF; end
                3: begin fg_value = 4'hF; bg_value = 4'h0; end
                5: begin fg_value = 4'h0; bg_value = 4'hF; end
                default:
                begin
                    fg_value = 4'($urandom);
                    bg_value = 4'($urandom);
                end
            endcase
            write_defaults(fg_value, bg_value);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (quiet_left == 0 && $urandom_range(0, 9) == 0)
                    quiet_left = $urandom_range(8, 24);
                rq = random_request();
                issue_request(rq, (quiet_left != 0) ? 0 : 6, 1'b0, '0);
                if (quiet_left != 0)
                    quiet_left--;
            end
        end

        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
